// ===== sv/spq_pkg.sv =====
// shared types, codes and sizes for the stable priority queue
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OCC_W    = 5;

    localparam logic [1:0] REQ_ENQ  = 2'd0;
    localparam logic [1:0] REQ_DEQ  = 2'd1;
    localparam logic [1:0] REQ_PEEK = 2'd2;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] item_value;
        logic signed [31:0] item_priority;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic [1:0]         status;
        logic [OCC_W-1:0]   occupancy;
    } t_out;

    typedef struct packed {
        logic cap_in;
        logic exec;
    } t_cmd;

endpackage

// ===== sv/stable_priority_queue_top.sv =====
// top level of the stable priority queue
// Bounded queue of up to CAPACITY (16) value/priority pairs, highest priority
// first, equal priorities in arrival order. Each request word (enqueue, dequeue,
// peek) gives one result word with a status, the occupancy after the request
// and, for dequeue and peek on a non-empty queue, the front value. A request is
// first registered, then all slots compare against the new priority in parallel
// and shift as one row; a new request word is taken only once the one before it
// has run. A waiting result holds its register until taken; the next request is
// still taken in the meantime and is run once that register frees up.
module stable_priority_queue_top
    import spq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_cmd cmd;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    spq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_out_data (o_out_data)
    );

endmodule

// ===== sv/spq_ctrl.sv =====
// handshake controller: takes a request word, runs it, holds the result word
module spq_ctrl
    import spq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;

    // result register empties this cycle or is already empty
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && i_out_stall;
        o_cmd.cap_in = 1'b0;
        o_cmd.exec   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/spq_dp.sv =====
// sorted slot row with parallel compare, insert shift and dequeue shift
module spq_dp
    import spq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_in_data,
    input  t_cmd i_cmd,
    output t_out o_out_data
);

    t_in                r_req;
    t_out               r_out, n_out;
    logic [CNT_W-1:0]   r_count, n_count;
    logic signed [31:0] r_slot_val [CAPACITY];
    logic signed [31:0] r_slot_pri [CAPACITY];
    logic [CAPACITY-1:0] keep;
    logic               is_full, is_empty, do_enq, do_deq;

    assign is_full  = (r_count >= CNT_W'(CAPACITY));
    assign is_empty = (r_count == '0);
    assign do_enq   = i_cmd.exec && (r_req.req_type == REQ_ENQ) && !is_full;
    assign do_deq   = i_cmd.exec && (r_req.req_type == REQ_DEQ) && !is_empty;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_req <= i_in_data;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_slot
            logic signed [31:0] ins_val, ins_pri;
            // slots at or after the insert point move back by one
            assign keep[g] = (CNT_W'(g) < r_count) && (r_slot_pri[g] >= r_req.item_priority);
            if (g == 0) begin : g_first
                always_comb begin
                    ins_val = keep[g] ? r_slot_val[g] : r_req.item_value;
                    ins_pri = keep[g] ? r_slot_pri[g] : r_req.item_priority;
                end
            end else begin : g_rest
                always_comb begin
                    if (keep[g]) begin
                        ins_val = r_slot_val[g];
                        ins_pri = r_slot_pri[g];
                    end else if (keep[g-1]) begin
                        ins_val = r_req.item_value;
                        ins_pri = r_req.item_priority;
                    end else begin
                        ins_val = r_slot_val[g-1];
                        ins_pri = r_slot_pri[g-1];
                    end
                end
            end
            if (g < CAPACITY - 1) begin : g_shift
                always_ff @(posedge i_clk) begin
                    if (do_enq) begin
                        r_slot_val[g] <= ins_val;
                        r_slot_pri[g] <= ins_pri;
                    end else if (do_deq) begin
                        r_slot_val[g] <= r_slot_val[g+1];
                        r_slot_pri[g] <= r_slot_pri[g+1];
                    end
                end
            end else begin : g_last
                always_ff @(posedge i_clk) begin
                    if (do_enq) begin
                        r_slot_val[g] <= ins_val;
                        r_slot_pri[g] <= ins_pri;
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (do_enq) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_deq) begin
            n_count = r_count - CNT_W'(1);
        end
        n_out.out_value = '0;
        n_out.status    = STS_OK;
        case (r_req.req_type) inside
            REQ_ENQ: begin
                if (is_full) begin
                    n_out.status = STS_FULL;
                end
            end
            REQ_DEQ, REQ_PEEK: begin
                if (is_empty) begin
                    n_out.status = STS_EMPTY;
                end else begin
                    n_out.out_value = r_slot_val[0];
                end
            end
            default: ;
        endcase
        n_out.occupancy = OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule

// ===== tb/tb_stable_priority_queue_top.sv =====
`timescale 1ns / 100ps
// testbench for the stable priority queue: directed table, random words, stall phases
module tb_stable_priority_queue_top;
    import spq_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         SHOW_MAX    = 10;

    typedef struct {
        t_in  word;
        bit   known;
        t_out reply;
    } t_stim;

    typedef struct {
        logic [1:0]         req;
        logic signed [31:0] value;
        logic signed [31:0] prio;
        int                 reps;
        bit                 known;
        t_out               reply;
    } t_row;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    stable_priority_queue_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // reply is only written in rows marked known; other rows take it from the shadow copy
    t_row directed_tbl [0:13] = '{
        '{REQ_PEEK,   32'sd0,           32'sd0,           1, 1'b1, '{32'sd0, STS_EMPTY, 5'd0}},
        '{REQ_DEQ,    32'sd0,           32'sd0,           1, 1'b1, '{32'sd0, STS_EMPTY, 5'd0}},
        '{REQ_UNUSED, 32'shFFFF_FFFF,   32'shFFFF_FFFF,   1, 1'b1, '{32'sd0, STS_OK, 5'd0}},
        '{REQ_ENQ,    32'sh7FFF_FFFF,   32'sh8000_0000,   1, 1'b1, '{32'sd0, STS_OK, 5'd1}},
        '{REQ_ENQ,    32'sh8000_0000,   32'sh7FFF_FFFF,   1, 1'b1, '{32'sd0, STS_OK, 5'd2}},
        '{REQ_PEEK,   32'sd0,           32'sd0,           1, 1'b1,
            '{32'sh8000_0000, STS_OK, 5'd2}},
        '{REQ_ENQ,    32'sd100,         32'sd0,           3, 1'b0, '0},
        '{REQ_ENQ,    -32'sd1,          -32'sd1,          1, 1'b0, '0},
        '{REQ_ENQ,    32'sd200,         32'sh7FFF_FFFF,   1, 1'b0, '0},
        '{REQ_UNUSED, 32'sh5555_5555,   32'shAAAA_AAAA,   1, 1'b0, '0},
        '{REQ_ENQ,    32'sd300,         -32'sd5,          9, 1'b0, '0},
        '{REQ_ENQ,    32'sd7,           32'sd7,           1, 1'b1, '{32'sd0, STS_FULL, 5'd16}},
        '{REQ_PEEK,   32'sd0,           32'sd0,           1, 1'b0, '0},
        '{REQ_DEQ,    32'sd0,           32'sd0,           3, 1'b0, '0}
    };

    t_stim request_q[$];
    t_out  expected_replies[$];

    // shadow copy of the queue contents, front at index 0
    logic signed [31:0] q_value [CAPACITY];
    logic signed [31:0] q_prio  [CAPACITY];
    int                 q_count = 0;

    int    send_idle_pct = 0;
    int    stall_pct     = 0;
    bit    send_paused   = 1'b0;
    int    hold_req      = 0;
    int    hold_left     = 0;
    int    mismatches    = 0;
    int    cycle_cnt     = 0;
    bit    word_live     = 1'b0;
    t_stim cur_stim;

    function automatic t_out serve_request(t_in w);
        t_out r;
        int   pos;
        r        = '0;
        r.status = STS_OK;
        case (w.req_type) inside
            REQ_ENQ: begin
                if (q_count >= CAPACITY) begin
                    r.status = STS_FULL;
                end else begin
                    // new entry goes behind every entry of equal or higher priority
                    pos = 0;
                    while (pos < q_count && q_prio[pos] >= w.item_priority)
                        pos++;
                    for (int i = q_count; i > pos; i--) begin
                        q_value[i] = q_value[i-1];
                        q_prio[i]  = q_prio[i-1];
                    end
                    q_value[pos] = w.item_value;
                    q_prio[pos]  = w.item_priority;
                    q_count++;
                end
            end
            REQ_DEQ, REQ_PEEK: begin
                if (q_count == 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    r.out_value = q_value[0];
                    if (w.req_type == REQ_DEQ) begin
                        for (int i = 0; i + 1 < q_count; i++) begin
                            q_value[i] = q_value[i+1];
                            q_prio[i]  = q_prio[i+1];
                        end
                        q_count--;
                    end
                end
            end
            default: ;
        endcase
        r.occupancy = OCC_W'(q_count);
        return r;
    endfunction

    task automatic log_mismatch(string what, t_out want, t_out got);
        mismatches++;
        if (mismatches <= SHOW_MAX)
            $display("%0t %s: exp value %0d status %0d occ %0d, got value %0d status %0d occ %0d",
                $time, what, want.out_value, want.status, want.occupancy,
                got.out_value, got.status, got.occupancy);
    endtask

    task automatic check_reply(t_out got);
        t_out want;
        if (expected_replies.size() == 0) begin
            log_mismatch("reply with nothing outstanding", '0, got);
        end else begin
            want = expected_replies.pop_front();
            if (got.out_value !== want.out_value || got.status !== want.status ||
                got.occupancy !== want.occupancy)
                log_mismatch("reply mismatch", want, got);
        end
    endtask

    // sender: one word held on the bus until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                t_out served;
                served = serve_request(cur_stim.word);
                expected_replies.push_back(cur_stim.known ? cur_stim.reply : served);
                word_live = 1'b0;
            end
            if (!word_live) begin
                if (!send_paused && request_q.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    cur_stim = request_q.pop_front();
                    i_in_data  <= cur_stim.word;
                    i_in_valid <= 1'b1;
                    word_live = 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stall, or a long hold-off when asked for one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            check_reply(o_out_data);
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic add_random(int n);
        t_stim s;
        int    mode;
        int    enq_lim;
        int    r;
        mode    = 2;
        enq_lim = 45;
        for (int k = 0; k < n; k++) begin
            // bursts that lean towards filling or draining reach both full and empty
            if (k % 16 == 0) begin
                mode    = $urandom_range(2);
                enq_lim = (mode == 0) ? 70 : (mode == 1) ? 25 : 45;
            end
            r = $urandom_range(99);
            if (r < enq_lim)
                s.word.req_type = REQ_ENQ;
            else if (r < 85)
                s.word.req_type = REQ_DEQ;
            else if (r < 97)
                s.word.req_type = REQ_PEEK;
            else
                s.word.req_type = REQ_UNUSED;
            s.word.item_value = $urandom;
            case ($urandom_range(5)) inside
                0:       s.word.item_priority = 32'sh8000_0000;
                1:       s.word.item_priority = 32'sh7FFF_FFFF;
                2, 3:    s.word.item_priority = 32'($urandom_range(3)) - 32'sd1;
                default: s.word.item_priority = $urandom;
            endcase
            s.known = 1'b0;
            s.reply = '0;
            request_q.push_back(s);
        end
    endtask

    task automatic wait_sent();
        while (request_q.size() > 0 || i_in_valid)
            @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (expected_replies.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(int idle, int stall, int n, int hold);
        @(negedge i_clk);
        send_idle_pct = idle;
        stall_pct     = stall;
        hold_req      = hold;
        add_random(n / 2);
        wait_sent();
        // sender holds back until every reply is home
        send_paused = 1'b1;
        wait_drained();
        send_paused = 1'b0;
        add_random(n - n / 2);
        wait_sent();
        wait_drained();
    endtask

    initial begin
        t_stim s;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed_tbl[r]) begin
            for (int k = 0; k < directed_tbl[r].reps; k++) begin
                s.word.req_type      = directed_tbl[r].req;
                s.word.item_value    = directed_tbl[r].value + k;
                s.word.item_priority = directed_tbl[r].prio;
                s.known              = directed_tbl[r].known;
                s.reply              = directed_tbl[r].reply;
                request_q.push_back(s);
            end
        end
        wait_sent();
        wait_drained();

        run_phase(0, 0, 100, 48);
        run_phase(67, 0, 100, 0);
        run_phase(0, 67, 100, 40);
        run_phase(25, 25, 100, 0);

        // leave room for any stray reply
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
